### src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants for the I2C master byte engine
// Command codes, sequencer state sizes, result record and segment tables.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // width of the half-period delay counter
  localparam int DELAY_BITS = 10;
  localparam int CFG_BITS   = 10;
  localparam logic [CFG_BITS-1:0] DELAY_RESET = CFG_BITS'(922);

  localparam int PHASE_BITS = 5;

  // command codes carried in the operation field
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_CHECK     = 3'd1,
    OP_START     = 3'd2,
    OP_STOP      = 3'd3,
    OP_WRITE     = 3'd4,
    OP_READ_ACK  = 3'd5,
    OP_READ_NACK = 3'd6
  } op_t;

  // segment counts per command
  localparam logic [PHASE_BITS-1:0] SEGS_CHECK = PHASE_BITS'(1);
  localparam logic [PHASE_BITS-1:0] SEGS_START = PHASE_BITS'(4);
  localparam logic [PHASE_BITS-1:0] SEGS_STOP  = PHASE_BITS'(4);
  localparam logic [PHASE_BITS-1:0] SEGS_WRITE = PHASE_BITS'(28);
  localparam logic [PHASE_BITS-1:0] SEGS_READ  = PHASE_BITS'(20);

  // position of a write segment inside its three-segment bit slot
  localparam logic [1:0] SLOT_SCL_LOW  = 2'd0;
  localparam logic [1:0] SLOT_SDA_SET  = 2'd1;
  localparam logic [1:0] SLOT_SCL_HIGH = 2'd2;

  localparam logic [1:0] SEG_MOD3 [32] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
    2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
  };

  // one result record, as stored in the output buffer
  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       fault;
  } res_t;

  // number of segments of a command
  function automatic logic [PHASE_BITS-1:0] seg_total(input op_t cmd);
    logic [PHASE_BITS-1:0] n;
    n = '0;
    case (cmd)
      OP_CHECK:     n = SEGS_CHECK;
      OP_START:     n = SEGS_START;
      OP_STOP:      n = SEGS_STOP;
      OP_WRITE:     n = SEGS_WRITE;
      OP_READ_ACK,
      OP_READ_NACK: n = SEGS_READ;
      default:      n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### src/i2cm_cmd_if.sv
// ----------------------------------------------------------------------------
// i2cm_cmd_if: command channel of the I2C master byte engine
// Valid/ready channel carrying one tick item: operation, tx byte, SDA sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output operation, output tx_byte, output sda_in,
                  input ready);
  modport sink   (input valid, input operation, input tx_byte, input sda_in,
                  output ready);
endinterface

`default_nettype wire

### src/i2cm_res_if.sv
// ----------------------------------------------------------------------------
// i2cm_res_if: result channel of the I2C master byte engine
// Valid/ready channel carrying the bus levels and status of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_drive;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       fault;

  modport source (output valid, output scl_drive, output sda_drive, output busy_res,
                  output done_res, output rx_byte, output fault, input ready);
  modport sink   (input valid, input scl_drive, input sda_drive, input busy_res,
                  input done_res, input rx_byte, input fault, output ready);
endinterface

`default_nettype wire

### src/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: tick-driven I2C master byte engine
// Bit-banged start, stop, bus check, byte write and byte read sequences.
// ----------------------------------------------------------------------------
// Each accepted transfer on the command channel is one timing tick; the engine
// takes one every clock cycle unless the channel stalls, and returns exactly
// one result per tick. The sequencer state update is a single pass of logic
// per tick, and results are registered in a two-entry output buffer, so the
// command channel only stalls in reset or when both entries hold results not
// yet taken. A command launched from idle runs each segment for
// delay_ticks+1 ticks; further commands are ignored until done is reported.
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [i2cm_pkg::CFG_BITS-1:0] cfg_wdata,
  i2cm_cmd_if.sink                           cmd,
  i2cm_res_if.source                         res
);

  logic [i2cm_pkg::CFG_BITS-1:0] delay_ticks;
  logic                          cmd_fire;
  logic                          res_fire;
  i2cm_pkg::res_t                step_res;
  i2cm_pkg::res_t                out_data;
  logic                          out_valid;
  i2cm_pkg::res_t                skid_data;
  logic                          skid_valid;

  // delay configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= i2cm_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      delay_ticks <= cfg_wdata;
    end
  end

  // no transfer is taken while in reset
  assign cmd.ready = !skid_valid && !rst;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res_fire  = out_valid && res.ready;

  // sequencer
  i2cm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (cmd_fire),
    .operation (cmd.operation),
    .tx_byte   (cmd.tx_byte),
    .sda_in    (cmd.sda_in),
    .delay_lim (i2cm_pkg::DELAY_BITS'(delay_ticks)),
    .res       (step_res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= cmd_fire;
      end
    end else if (cmd_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload of the output buffer
  always_ff @(posedge clk) begin
    if (res_fire || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (cmd_fire) begin
        out_data <= step_res;
      end
    end else if (cmd_fire) begin
      skid_data <= step_res;
    end
  end

  assign res.valid     = out_valid;
  assign res.scl_drive = out_data.scl_drive;
  assign res.sda_drive = out_data.sda_drive;
  assign res.busy_res  = out_data.busy_res;
  assign res.done_res  = out_data.done_res;
  assign res.rx_byte   = out_data.rx_byte;
  assign res.fault     = out_data.fault;

endmodule

`default_nettype wire

### src/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq: I2C bus segment sequencer
// Advances the segment/delay state by one tick per step and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic [2:0]                      operation,
  input  wire logic [7:0]                      tx_byte,
  input  wire logic                            sda_in,
  input  wire logic [i2cm_pkg::DELAY_BITS-1:0] delay_lim,
  output i2cm_pkg::res_t                       res
);

  logic [i2cm_pkg::PHASE_BITS-1:0] phase, phase_next;
  i2cm_pkg::op_t                   cmd, cmd_next;
  logic [i2cm_pkg::DELAY_BITS-1:0] delay_count, delay_count_next;
  logic [7:0]                      shift_reg, shift_reg_next;
  logic [7:0]                      received_reg, received_reg_next;
  logic                            scl_level, scl_level_next;
  logic                            sda_level, sda_level_next;
  logic                            fault_flag, fault_flag_next;

  logic [i2cm_pkg::PHASE_BITS-1:0] seg;
  logic [i2cm_pkg::PHASE_BITS-1:0] seg_inc;
  logic                            done;

  // state registers, advanced once per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      cmd          <= i2cm_pkg::OP_TICK;
      delay_count  <= '0;
      shift_reg    <= '0;
      received_reg <= '0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      fault_flag   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      cmd          <= cmd_next;
      delay_count  <= delay_count_next;
      shift_reg    <= shift_reg_next;
      received_reg <= received_reg_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
      fault_flag   <= fault_flag_next;
    end
  end

  // one tick of the sequencer
  always_comb begin
    phase_next        = phase;
    cmd_next          = cmd;
    delay_count_next  = delay_count;
    shift_reg_next    = shift_reg;
    received_reg_next = received_reg;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    fault_flag_next   = fault_flag;
    done              = 1'b0;
    seg               = '0;
    seg_inc           = '0;

    // command launch from idle
    if (phase == '0 && operation inside
        {[i2cm_pkg::OP_CHECK : i2cm_pkg::OP_READ_NACK]}) begin
      cmd_next         = i2cm_pkg::op_t'(operation);
      shift_reg_next   = (operation == i2cm_pkg::OP_WRITE) ? tx_byte : 8'h00;
      fault_flag_next  = 1'b0;
      delay_count_next = '0;
      phase_next       = i2cm_pkg::PHASE_BITS'(1);
    end

    if (phase_next != '0) begin
      seg = phase_next - i2cm_pkg::PHASE_BITS'(1);

      // level changes on the first tick of a segment
      if (delay_count_next == '0) begin
        case (cmd_next)
          i2cm_pkg::OP_CHECK: begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
          end
          i2cm_pkg::OP_START: begin
            if (seg == 5'd0) begin
              scl_level_next = 1'b1;
            end else if (seg == 5'd3) begin
              sda_level_next = 1'b0;
            end
          end
          i2cm_pkg::OP_STOP: begin
            case (seg)
              5'd0:    scl_level_next = 1'b0;
              5'd1:    sda_level_next = 1'b0;
              5'd2:    scl_level_next = 1'b1;
              default: sda_level_next = 1'b1;
            endcase
          end
          i2cm_pkg::OP_WRITE: begin
            if (seg < 5'd24) begin
              case (i2cm_pkg::SEG_MOD3[seg])
                i2cm_pkg::SLOT_SCL_LOW: scl_level_next = 1'b0;
                i2cm_pkg::SLOT_SDA_SET: begin
                  sda_level_next = shift_reg_next[7];
                  shift_reg_next = {shift_reg_next[6:0], 1'b0};
                end
                default: scl_level_next = 1'b1;
              endcase
            end else if (seg == 5'd24) begin
              scl_level_next = 1'b0;
            end else if (seg == 5'd25) begin
              sda_level_next = 1'b1;
            end else if (seg == 5'd26) begin
              scl_level_next = 1'b1;
            end else begin
              scl_level_next = 1'b0;
            end
          end
          i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NACK: begin
            if (seg < 5'd16) begin
              if (!seg[0]) begin
                if (seg == 5'd0) begin
                  sda_level_next = 1'b1;
                end
                scl_level_next = 1'b0;
              end else begin
                scl_level_next = 1'b1;
              end
            end else if (seg == 5'd16) begin
              scl_level_next    = 1'b0;
              received_reg_next = shift_reg_next;
            end else if (seg == 5'd17) begin
              sda_level_next = (cmd_next == i2cm_pkg::OP_READ_NACK);
            end else if (seg == 5'd18) begin
              scl_level_next = 1'b1;
            end else begin
              scl_level_next = 1'b0;
            end
          end
          default: ;
        endcase
      end

      // last tick of a segment: sample SDA and move on
      if (delay_count_next >= delay_lim) begin
        case (cmd_next)
          i2cm_pkg::OP_CHECK: begin
            if (!sda_in) fault_flag_next = 1'b1;
          end
          i2cm_pkg::OP_START: begin
            if (seg == 5'd3 && sda_in) fault_flag_next = 1'b1;
          end
          i2cm_pkg::OP_WRITE: begin
            if (seg == 5'd26 && sda_in) fault_flag_next = 1'b1;
          end
          i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NACK: begin
            if (seg < 5'd16 && seg[0]) begin
              shift_reg_next = {shift_reg_next[6:0], sda_in};
            end
          end
          default: ;
        endcase
        delay_count_next = '0;
        seg_inc          = seg + i2cm_pkg::PHASE_BITS'(1);
        if (seg_inc >= i2cm_pkg::seg_total(cmd_next)) begin
          phase_next = '0;
          done       = 1'b1;
        end else begin
          phase_next = seg_inc + i2cm_pkg::PHASE_BITS'(1);
        end
      end else begin
        delay_count_next = delay_count_next + i2cm_pkg::DELAY_BITS'(1);
      end
    end

    res.scl_drive = scl_level_next;
    res.sda_drive = sda_level_next;
    res.busy_res  = (phase_next != '0);
    res.done_res  = done;
    res.rx_byte   = received_reg_next;
    res.fault     = done & fault_flag_next;
  end

endmodule

`default_nettype wire
